>>> hdl/dsdq_pkg.sv
`default_nettype none

package dsdq_pkg;

  localparam int NUM_TAGS_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int KEY_W = 18;
  localparam int ID_W  = 8;
  localparam int CFG_W = 4;

  localparam logic [CFG_W-1:0] TAGS_IN_USE_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NULL_TAG  = 3'd1,
    ST_TAG_HIGH  = 3'd2,
    ST_ZERO_SIZE = 3'd3,
    ST_FULL      = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_POP    = 1'b1
  } mode_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    mode_t        mode;
    logic [3:0]   tag;
    logic [7:0]   object_id;
    logic [15:0]  top_y;
    logic [15:0]  height;
    logic [15:0]  width;
  } cmd_t;

  typedef struct packed {
    status_t      status;
    logic [7:0]   popped_id;
    logic         now_empty;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/dsdq_ram.sv
`default_nettype none

module dsdq_ram #(
  parameter int DEPTH  = dsdq_pkg::NUM_TAGS_DEF * dsdq_pkg::QUEUE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire                   clk,
  input  wire                   we,
  input  wire [ADDR_W-1:0]      waddr,
  input  wire dsdq_pkg::entry_t wdata,
  input  wire [ADDR_W-1:0]      raddr,
  output dsdq_pkg::entry_t      rdata
);

  dsdq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/dsdq_ctrl.sv
`default_nettype none

module dsdq_ctrl #(
  parameter int NUM_TAGS    = dsdq_pkg::NUM_TAGS_DEF,
  parameter int QUEUE_DEPTH = dsdq_pkg::QUEUE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(NUM_TAGS * QUEUE_DEPTH)
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire dsdq_pkg::cmd_t           cmd_in,
  input  wire [dsdq_pkg::CFG_W-1:0]     tags_in_use,
  output logic                          busy,
  output logic                          res_valid,
  output dsdq_pkg::res_t                res,
  output logic                          mem_we,
  output logic [ADDR_W-1:0]             mem_waddr,
  output dsdq_pkg::entry_t              mem_wdata,
  output logic [ADDR_W-1:0]             mem_raddr,
  input  wire dsdq_pkg::entry_t         mem_rdata
);

  localparam int QW    = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [3:0]       NT4  = 4'(NUM_TAGS);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_WALK   = 6'b000100,
    S_PLACE  = 6'b001000,
    S_HEAD   = 6'b010000,
    S_SHIFT  = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  dsdq_pkg::cmd_t           cmd_r, cmd_nxt;
  logic [dsdq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [7:0]               head_r, head_nxt;
  dsdq_pkg::res_t           res_r, res_nxt;
  logic                     res_valid_r, res_valid_nxt;
  logic [CNT_W-1:0]         cnt_r [NUM_TAGS];
  logic [CNT_W-1:0]         cnt_nxt [NUM_TAGS];

  logic [QW-1:0]            q;
  logic [CNT_W-1:0]         n;
  logic [3:0]               limit;
  dsdq_pkg::entry_t         new_entry;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [QW-1:0] qq,
                                                input logic [IDX_W-1:0] ii);
    int a;
    a = int'(qq) * QUEUE_DEPTH + int'(ii);
    return ADDR_W'(a);
  endfunction

  assign q         = QW'(cmd_r.tag - 4'd1);
  assign n         = cnt_r[q];
  assign limit     = (tags_in_use > NT4) ? NT4 : tags_in_use;
  assign new_entry = '{key: key_r, id: cmd_r.object_id};

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    res_nxt       = res_r;
    res_valid_nxt = 1'b0;
    cnt_nxt       = cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = new_entry;
    mem_raddr     = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd_in;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        key_nxt = {{2{cmd_r.top_y[15]}}, cmd_r.top_y} + {2'b00, cmd_r.height};
        if (cmd_r.tag == 4'd0) begin
          res_nxt       = '{status: dsdq_pkg::ST_NULL_TAG, popped_id: 8'd0, now_empty: 1'b0};
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (cmd_r.tag > limit) begin
          res_nxt       = '{status: dsdq_pkg::ST_TAG_HIGH, popped_id: 8'd0, now_empty: 1'b0};
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (cmd_r.mode == dsdq_pkg::MODE_INSERT) begin
          if (cmd_r.width == 16'd0 || cmd_r.height == 16'd0) begin
            res_nxt       = '{status: dsdq_pkg::ST_ZERO_SIZE, popped_id: 8'd0,
                              now_empty: (n == '0)};
            res_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (n == FULL) begin
            res_nxt       = '{status: dsdq_pkg::ST_FULL, popped_id: 8'd0, now_empty: 1'b0};
            res_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (n == '0) begin
            idx_nxt   = '0;
            state_nxt = S_PLACE;
          end else begin
            idx_nxt   = IDX_W'(n - 1'b1);
            mem_raddr = addr_of(q, IDX_W'(n - 1'b1));
            state_nxt = S_WALK;
          end
        end else begin
          if (n == '0) begin
            res_nxt       = '{status: dsdq_pkg::ST_EMPTY, popped_id: 8'd0, now_empty: 1'b1};
            res_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            mem_raddr = addr_of(q, '0);
            state_nxt = S_HEAD;
          end
        end
      end
      S_WALK: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(q, IDX_W'(idx_r + 1'b1));
        if ($signed(mem_rdata.key) > $signed(key_r)) begin
          mem_wdata = mem_rdata;
          if (idx_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            idx_nxt   = IDX_W'(idx_r - 1'b1);
            mem_raddr = addr_of(q, IDX_W'(idx_r - 1'b1));
          end
        end else begin
          cnt_nxt[q]    = CNT_W'(n + 1'b1);
          res_nxt       = '{status: dsdq_pkg::ST_OK, popped_id: 8'd0, now_empty: 1'b0};
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_PLACE: begin
        mem_we        = 1'b1;
        mem_waddr     = addr_of(q, idx_r);
        cnt_nxt[q]    = CNT_W'(n + 1'b1);
        res_nxt       = '{status: dsdq_pkg::ST_OK, popped_id: 8'd0, now_empty: 1'b0};
        res_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_HEAD: begin
        if (n == CNT_W'(1)) begin
          cnt_nxt[q]    = '0;
          res_nxt       = '{status: dsdq_pkg::ST_OK, popped_id: mem_rdata.id,
                            now_empty: 1'b1};
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          head_nxt  = mem_rdata.id;
          idx_nxt   = IDX_W'(1);
          mem_raddr = addr_of(q, IDX_W'(1));
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(q, IDX_W'(idx_r - 1'b1));
        mem_wdata = mem_rdata;
        if (idx_r == IDX_W'(n - 1'b1)) begin
          cnt_nxt[q]    = CNT_W'(n - 1'b1);
          res_nxt       = '{status: dsdq_pkg::ST_OK, popped_id: head_r, now_empty: 1'b0};
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt   = IDX_W'(idx_r + 1'b1);
          mem_raddr = addr_of(q, IDX_W'(idx_r + 1'b1));
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      for (int t = 0; t < NUM_TAGS; t++) begin
        cnt_r[t] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    idx_r  <= idx_nxt;
    head_r <= head_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

>>> hdl/depth_sorted_draw_queue_top.sv
// Channel   Handshake                Payload
// input     start, busy              in_mode, in_tag, in_object_id, in_top_y,
//                                    in_sprite_height, in_sprite_width
// result    out_valid (one cycle)    out_status, out_popped_id, out_now_empty
// config    cfg_valid, cfg_ready     cfg_tags_in_use
//
// A rejected item gets its result straight from the decide step. An insert walks
// from the tail, moving each entry with a larger key up one place, then writes the
// new entry; a pop reads the head and moves each later entry down one place. The
// entry memory moves one entry a cycle through its single read and single write port.
// Reset clears every queue count and sets tags_in_use to 8; busy is low after reset.
// Results cannot be held off: each is shown for exactly one cycle.
`default_nettype none

module depth_sorted_draw_queue_top #(
  parameter int NUM_TAGS    = dsdq_pkg::NUM_TAGS_DEF,
  parameter int QUEUE_DEPTH = dsdq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire                         in_mode,
  input  wire [3:0]                   in_tag,
  input  wire [7:0]                   in_object_id,
  input  wire signed [15:0]           in_top_y,
  input  wire [15:0]                  in_sprite_height,
  input  wire [15:0]                  in_sprite_width,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [7:0]                  out_popped_id,
  output logic                        out_now_empty,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [dsdq_pkg::CFG_W-1:0]   cfg_tags_in_use
);

  localparam int ADDR_W = (NUM_TAGS * QUEUE_DEPTH > 1) ? $clog2(NUM_TAGS * QUEUE_DEPTH) : 1;

  logic [dsdq_pkg::CFG_W-1:0] tags_r, tags_nxt;
  dsdq_pkg::cmd_t             cmd;
  dsdq_pkg::res_t             res;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [ADDR_W-1:0]          mem_raddr;
  dsdq_pkg::entry_t           mem_wdata;
  dsdq_pkg::entry_t           mem_rdata;

  assign cfg_ready = 1'b1;
  assign tags_nxt  = (cfg_valid && cfg_ready) ? cfg_tags_in_use : tags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tags_r <= dsdq_pkg::TAGS_IN_USE_RESET;
    end else begin
      tags_r <= tags_nxt;
    end
  end

  assign cmd = '{mode: dsdq_pkg::mode_t'(in_mode), tag: in_tag, object_id: in_object_id,
                 top_y: in_top_y, height: in_sprite_height, width: in_sprite_width};

  dsdq_ctrl #(
    .NUM_TAGS    (NUM_TAGS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .cmd_in      (cmd),
    .tags_in_use (tags_r),
    .busy        (busy),
    .res_valid   (out_valid),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  dsdq_ram #(
    .DEPTH  (NUM_TAGS * QUEUE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_status    = res.status;
  assign out_popped_id = res.popped_id;
  assign out_now_empty = res.now_empty;

endmodule

`default_nettype wire

>>> hdl/dsdq_checker.sv
`default_nettype none

module dsdq_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       start,
  input wire       busy,
  input wire       out_valid,
  input wire [2:0] out_status,
  input wire [7:0] out_popped_id,
  input wire       out_now_empty
);

  // Every transfer makes the block busy until its result appears.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer did not make the block busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result without preceding work");

  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("work ended without a result");

  a_reject_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dsdq_pkg::ST_OK |-> out_popped_id == 8'd0)
    else $error("popped id on a failed request");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dsdq_pkg::ST_EMPTY |-> out_now_empty)
    else $error("empty status without empty flag");

endmodule

bind depth_sorted_draw_queue_top dsdq_checker u_chk (.*);

`default_nettype wire
